@@ src/sdspi_pkg.sv @@
// Package for the SD card SPI-mode host sequencer.
// Holds request, result and error codes, the phase type and the item structs.
package sdspi_pkg;

    localparam int BLOCK_BYTES_DEF = 512;
    localparam int DUMMY_BYTES_DEF = 8;

    typedef enum logic [3:0] {
        C_BYTE = 4'd0, C_INIT = 4'd1, C_RSTART = 4'd2, C_RBLOCK = 4'd3, C_RSTOP = 4'd4,
        C_WSTART = 4'd5, C_WBYTE = 4'd6, C_WSTOP = 4'd7, C_TICK = 4'd8
    } t_cmd;

    localparam logic [2:0] K_XFER = 3'd0;
    localparam logic [2:0] K_RDATA_OUT = 3'd1;
    localparam logic [2:0] K_DONE = 3'd2;
    localparam logic [2:0] K_FAIL = 3'd3;
    localparam logic [2:0] K_NEED = 3'd4;

    localparam logic [2:0] E_TIMEOUT = 3'd1;
    localparam logic [2:0] E_R1 = 3'd2;
    localparam logic [2:0] E_ECHO = 3'd3;
    localparam logic [2:0] E_TOKEN = 3'd4;
    localparam logic [2:0] E_WREJ = 3'd5;
    localparam logic [2:0] E_STATUS = 3'd6;
    localparam logic [2:0] E_BUSY = 3'd7;

    localparam logic [1:0] REG_RESP = 2'd0;
    localparam logic [1:0] REG_INIT = 2'd1;
    localparam logic [1:0] REG_TOKEN = 2'd2;
    localparam logic [1:0] REG_BUSY = 2'd3;

    typedef enum logic [36:0] {
        P_IDLE = 37'd1 << 0, P_RD_READY = 37'd1 << 1, P_WR_READY = 37'd1 << 2,
        P_WNEED = 37'd1 << 3, P_DUMMY = 37'd1 << 4, P_CMD_WAIT = 37'd1 << 5,
        P_CMD_SEND = 37'd1 << 6, P_STUFF = 37'd1 << 7, P_CMD_R1 = 37'd1 << 8,
        P_R32 = 37'd1 << 9, P_BUSY = 37'd1 << 10, P_FINISH = 37'd1 << 11,
        P_TOKEN = 37'd1 << 12, P_RDATA = 37'd1 << 13, P_RCRC = 37'd1 << 14,
        P_WSTUFF = 37'd1 << 15, P_WTOKEN = 37'd1 << 16, P_WDATA = 37'd1 << 17,
        P_WCRC = 37'd1 << 18, P_WRESP = 37'd1 << 19, P_STOPTOK = 37'd1 << 20,
        P_STOPDUM = 37'd1 << 21, P_STATUS = 37'd1 << 22,
        R_CMD0 = 37'd1 << 23, R_CMD8 = 37'd1 << 24, R_R7 = 37'd1 << 25,
        R_CMD55 = 37'd1 << 26, R_CMD41 = 37'd1 << 27, R_CMD58 = 37'd1 << 28,
        R_OCR = 37'd1 << 29, R_CMD18 = 37'd1 << 30, R_CMD25 = 37'd1 << 31,
        R_CMD12 = 37'd1 << 32, R_FIN = 37'd1 << 33, R_WDONE = 37'd1 << 34,
        R_STOPBUSY = 37'd1 << 35, R_CMD13 = 37'd1 << 36
    } t_phase;

    typedef struct packed {
        logic [3:0]  cmd;
        logic [7:0]  miso_byte;
        logic [31:0] block_addr;
        logic [7:0]  write_byte;
    } t_req;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] mosi_byte;
        logic       select_active;
        logic       slow_clock;
        logic [7:0] data_out;
        logic [2:0] error_code;
        logic       last;
        logic       high_capacity;
    } t_res;

endpackage

@@ src/sd_spi_host_sequencer_top.sv @@
// SD card SPI-mode host sequencer, top level.
// Depends on sdspi_pkg, sdspi_front, sdspi_back, sdspi_out.
//
// One item a cycle sustained while items give at most one result and results are taken: each request or card
// byte is one state update in the back end, set by its single next-state step; a short
// request queue and a four-entry result queue decouple the channels. Each item gives zero
// to two results; the back end holds off when fewer than two result slots are free. The
// result port hands out one item a cycle while it is ready, so a run of read data bytes (two results
// each) is paced by the result port, not the back end. Results are offered once their item has
// passed the request queue and the back end has written them into the result queue.
module sd_spi_host_sequencer_top
    import sdspi_pkg::*;
#(
    parameter int BLOCK_BYTES = BLOCK_BYTES_DEF,
    parameter int DUMMY_BYTES = DUMMY_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [3:0]  i_cmd,
    input  logic [7:0]  i_miso_byte,
    input  logic [31:0] i_block_addr,
    input  logic [7:0]  i_write_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_kind,
    output logic [7:0]  o_mosi_byte,
    output logic        o_select_active,
    output logic        o_slow_clock,
    output logic [7:0]  o_data_out,
    output logic [2:0]  o_error_code,
    output logic        o_last,
    output logic        o_high_capacity,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    logic [15:0] r_resp_to, r_init_lim, r_token_to, r_busy_to;
    t_req        w_in, w_q;
    logic        w_q_valid, w_q_ready, w_room;
    logic [1:0]  w_n;
    t_res        w_r0, w_r1, w_out;

    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_resp_to <= 16'd1000; r_init_lim <= 16'd1250;
            r_token_to <= 16'd5000; r_busy_to <= 16'd1000;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_RESP:  r_resp_to <= i_cfg_data;
                REG_INIT:  r_init_lim <= i_cfg_data;
                REG_TOKEN: r_token_to <= i_cfg_data;
                default:   r_busy_to <= i_cfg_data;
            endcase
        end
    end

    assign w_in = '{cmd: i_cmd, miso_byte: i_miso_byte, block_addr: i_block_addr,
                    write_byte: i_write_byte};

    sdspi_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_req(w_in), .o_valid(w_q_valid), .i_ready(w_q_ready), .o_req(w_q)
    );

    sdspi_back #(.BLOCK_BYTES(BLOCK_BYTES), .DUMMY_BYTES(DUMMY_BYTES)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(w_q_valid), .o_ready(w_q_ready),
        .i_req(w_q), .i_room(w_room), .i_resp_to(r_resp_to), .i_init_lim(r_init_lim),
        .i_token_to(r_token_to), .i_busy_to(r_busy_to), .o_nres(w_n),
        .o_res0(w_r0), .o_res1(w_r1)
    );

    sdspi_out u_out (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_n(w_n), .i_res0(w_r0), .i_res1(w_r1),
        .o_room(w_room), .o_valid(o_valid), .i_ready(i_ready), .o_res(w_out)
    );

    assign o_kind          = w_out.kind;
    assign o_mosi_byte     = w_out.mosi_byte;
    assign o_select_active = w_out.select_active;
    assign o_slow_clock    = w_out.slow_clock;
    assign o_data_out      = w_out.data_out;
    assign o_error_code    = w_out.error_code;
    assign o_last          = w_out.last;
    assign o_high_capacity = w_out.high_capacity;
endmodule

@@ src/sdspi_fifo.sv @@
// Small valid/ready queue, used as the request queue between front and back.
// Depends on nothing; payload width is a parameter.
module sdspi_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [WIDTH-1:0] o_data
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wp, r_rp;
    logic [AW:0]      r_cnt;
    logic             w_push, w_pop;

    assign o_ready = (r_cnt != (AW+1)'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wp <= (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + 1'b1;
            if (w_pop) r_rp <= (r_rp == AW'(DEPTH-1)) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(w_push) - (AW+1)'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wp] <= i_data;
    end
endmodule

@@ src/sdspi_front.sv @@
// Front end: accepts request items, drops codes with no meaning, queues the rest.
// Depends on sdspi_pkg and sdspi_fifo.
module sdspi_front
    import sdspi_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_req        i_req,
    output logic        o_valid,
    input  logic        i_ready,
    output t_req        o_req
);
    logic w_keep, w_q_ready;

    assign w_keep  = (i_req.cmd <= 4'(C_TICK));
    assign o_ready = w_q_ready || !w_keep;

    sdspi_fifo #(.WIDTH($bits(t_req)), .DEPTH(2)) u_q (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid && w_keep), .o_ready(w_q_ready), .i_data(i_req),
        .o_valid(o_valid), .i_ready(i_ready), .o_data(o_req)
    );
endmodule

@@ src/sdspi_back.sv @@
// Back end: the card sequencer. Takes one queued item per cycle when the result
// queue has room for two, and pushes up to two result items. Depends on sdspi_pkg.
module sdspi_back
    import sdspi_pkg::*;
#(
    parameter int BLOCK_BYTES = BLOCK_BYTES_DEF,
    parameter int DUMMY_BYTES = DUMMY_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_req        i_req,
    input  logic        i_room,
    input  logic [15:0] i_resp_to,
    input  logic [15:0] i_init_lim,
    input  logic [15:0] i_token_to,
    input  logic [15:0] i_busy_to,
    output logic [1:0]  o_nres,
    output t_res        o_res0,
    output t_res        o_res1
);
    t_phase      r_phase, n_phase, r_ret, n_ret;
    logic [9:0]  r_cnt, n_cnt;
    logic [15:0] r_ms, n_ms, r_it, n_it;
    logic        r_bm, n_bm, r_sel, n_sel, r_slow, n_slow;
    logic [31:0] r_rs, n_rs, r_arg, n_arg;
    logic [5:0]  r_idx, n_idx;
    logic [1:0]  nres;
    t_res        res0, res1;
    logic [7:0]  b;
    logic        go;

    assign o_ready = i_room;
    assign go      = i_valid && i_room;
    assign b       = i_req.miso_byte;
    assign o_nres  = nres;
    assign o_res0  = res0;
    assign o_res1  = res1;

    function automatic logic [7:0] cmd_byte(input logic [2:0] i, input logic [5:0] idx,
                                            input logic [31:0] arg);
        case (i)
            3'd0: cmd_byte = 8'h40 | {2'b00, idx};
            3'd1: cmd_byte = arg[31:24];
            3'd2: cmd_byte = arg[23:16];
            3'd3: cmd_byte = arg[15:8];
            3'd4: cmd_byte = arg[7:0];
            default: cmd_byte = (idx == 6'd0) ? 8'h95 : ((idx == 6'd8) ? 8'h87 : 8'hff);
        endcase
    endfunction

    always_comb begin
        t_res e;
        n_phase = r_phase; n_ret = r_ret; n_cnt = r_cnt; n_ms = r_ms; n_it = r_it;
        n_bm = r_bm; n_sel = r_sel; n_slow = r_slow; n_rs = r_rs; n_arg = r_arg;
        n_idx = r_idx;
        nres = 2'd0;
        res0 = '0;
        res1 = '0;
        e = '0;
        // e: one result built by arms; flags filled at end
        if (go) begin
            case (i_req.cmd)
                4'(C_BYTE): begin
                    unique case (r_phase)
                        P_DUMMY: begin
                            n_cnt = r_cnt + 10'd1;
                            e.kind = K_XFER; e.mosi_byte = 8'hff; nres = 2'd1;
                            if (n_cnt >= 10'(DUMMY_BYTES)) begin
                                n_sel = 1'b1; n_idx = 6'd0; n_arg = '0; n_ret = R_CMD0;
                                n_ms = '0; n_phase = P_CMD_WAIT;
                            end
                        end
                        P_CMD_WAIT: begin
                            nres = 2'd1;
                            if (b == 8'hff) begin
                                n_cnt = '0; n_phase = P_CMD_SEND;
                                e.mosi_byte = cmd_byte(3'd0, r_idx, r_arg);
                            end else if (r_ms >= i_busy_to) begin
                                e.kind = K_FAIL; e.error_code = E_BUSY;
                            end else e.mosi_byte = 8'hff;
                        end
                        P_CMD_SEND: begin
                            n_cnt = r_cnt + 10'd1; nres = 2'd1;
                            if (n_cnt < 10'd6) e.mosi_byte = cmd_byte(n_cnt[2:0], r_idx, r_arg);
                            else begin
                                n_ms = '0; e.mosi_byte = 8'hff;
                                n_phase = (r_idx == 6'd12) ? P_STUFF : P_CMD_R1;
                            end
                        end
                        P_STUFF: begin
                            n_phase = P_CMD_R1; nres = 2'd1; e.mosi_byte = 8'hff;
                        end
                        P_CMD_R1: begin
                            if (b[7]) begin
                                nres = 2'd1;
                                if (r_ms >= i_resp_to) begin
                                    e.kind = K_FAIL; e.error_code = E_TIMEOUT;
                                end else e.mosi_byte = 8'hff;
                            end else if (r_idx != 6'd12 && b[7:1] != 7'd0) begin
                                nres = 2'd1;
                                e.kind = K_FAIL; e.error_code = E_R1;
                            end else begin
                                n_rs = {24'd0, b};
                                n_phase = P_IDLE; // resume below
                            end
                        end
                        P_R32: begin
                            n_rs = {r_rs[23:0], b}; n_cnt = r_cnt + 10'd1;
                            if (n_cnt < 10'd4) begin
                                nres = 2'd1; e.mosi_byte = 8'hff;
                            end
                        end
                        P_BUSY: begin
                            if (b != 8'hff) begin
                                nres = 2'd1;
                                if (r_ms >= i_busy_to) begin
                                    e.kind = K_FAIL; e.error_code = E_BUSY;
                                end else e.mosi_byte = 8'hff;
                            end
                        end
                        P_FINISH: begin
                            n_slow = 1'b0; n_phase = P_IDLE; nres = 2'd1; e.kind = K_DONE;
                        end
                        P_TOKEN: begin
                            nres = 2'd1;
                            if (b == 8'hff) begin
                                if (r_ms >= i_token_to) begin
                                    e.kind = K_FAIL; e.error_code = E_TIMEOUT;
                                end else e.mosi_byte = 8'hff;
                            end else if (b != 8'hfe) begin
                                e.kind = K_FAIL; e.error_code = E_TOKEN;
                            end else begin
                                n_cnt = '0; n_phase = P_RDATA; e.mosi_byte = 8'hff;
                            end
                        end
                        P_RDATA: begin
                            nres = 2'd2;
                            res0.kind = K_RDATA_OUT; res0.data_out = b;
                            res0.last = (r_cnt == 10'(BLOCK_BYTES-1));
                            res0.high_capacity = r_bm;
                            n_cnt = r_cnt + 10'd1;
                            if (res0.last) begin
                                n_cnt = '0; n_phase = P_RCRC;
                            end
                            e.mosi_byte = 8'hff;
                        end
                        P_RCRC: begin
                            n_cnt = r_cnt + 10'd1; nres = 2'd1;
                            if (n_cnt < 10'd2) e.mosi_byte = 8'hff;
                            else begin
                                e.kind = K_DONE; n_phase = P_RD_READY;
                            end
                        end
                        P_WSTUFF: begin
                            n_phase = P_WTOKEN; nres = 2'd1; e.mosi_byte = 8'hfc;
                        end
                        P_WTOKEN: begin
                            n_cnt = '0; n_phase = P_WDATA; nres = 2'd1;
                            e.mosi_byte = r_rs[7:0];
                        end
                        P_WDATA: begin
                            n_cnt = r_cnt + 10'd1; nres = 2'd1;
                            if (n_cnt < 10'(BLOCK_BYTES)) begin
                                n_phase = P_WNEED; e.kind = K_NEED;
                            end else begin
                                n_cnt = '0; n_phase = P_WCRC; e.mosi_byte = 8'hff;
                            end
                        end
                        P_WCRC: begin
                            n_cnt = r_cnt + 10'd1; nres = 2'd1; e.mosi_byte = 8'hff;
                            if (n_cnt >= 10'd2) n_phase = P_WRESP;
                        end
                        P_WRESP: begin
                            nres = 2'd1;
                            if (b[4:0] != 5'h05) begin
                                e.kind = K_FAIL; e.error_code = E_WREJ;
                            end else begin
                                n_ret = R_WDONE; n_ms = '0; n_phase = P_BUSY;
                                e.mosi_byte = 8'hff;
                            end
                        end
                        P_STOPTOK: begin
                            n_phase = P_STOPDUM; nres = 2'd1; e.mosi_byte = 8'hff;
                        end
                        P_STOPDUM: begin
                            n_ret = R_STOPBUSY; n_ms = '0; n_phase = P_BUSY; nres = 2'd1;
                            e.mosi_byte = 8'hff;
                        end
                        P_STATUS: begin
                            nres = 2'd1;
                            if (b != 8'd0) begin
                                e.kind = K_FAIL; e.error_code = E_STATUS;
                            end else begin
                                n_sel = 1'b0; n_phase = P_FINISH; e.mosi_byte = 8'hff;
                            end
                        end
                        default: ;
                    endcase
                    // resume after R1 accepted, R32 complete, or busy released
                    if ((r_phase == P_CMD_R1 && !b[7] && nres == 2'd0)
                        || (r_phase == P_R32 && n_cnt >= 10'd4)
                        || (r_phase == P_BUSY && b == 8'hff)) begin
                        nres = 2'd1;
                        e.mosi_byte = 8'hff;
                        unique case (r_ret)
                            R_CMD0: begin
                                n_idx = 6'd8; n_arg = 32'h1aa; n_ret = R_CMD8; n_ms = '0;
                                n_phase = P_CMD_WAIT;
                            end
                            R_CMD8, R_CMD58: begin
                                n_ret = (r_ret == R_CMD8) ? R_R7 : R_OCR;
                                n_rs = '0; n_cnt = '0; n_phase = P_R32;
                            end
                            R_R7: begin
                                if (n_rs != 32'h1aa) begin
                                    e.kind = K_FAIL; e.error_code = E_ECHO; e.mosi_byte = '0;
                                end else begin
                                    n_it = '0; n_idx = 6'd55; n_arg = '0; n_ret = R_CMD55;
                                    n_ms = '0; n_phase = P_CMD_WAIT;
                                end
                            end
                            R_CMD55: begin
                                n_idx = 6'd41; n_arg = 32'h4000_0000; n_ret = R_CMD41;
                                n_ms = '0; n_phase = P_CMD_WAIT;
                            end
                            R_CMD41: begin
                                if (n_rs[7:0] == 8'd0) begin
                                    n_idx = 6'd58; n_arg = '0; n_ret = R_CMD58;
                                    n_ms = '0; n_phase = P_CMD_WAIT;
                                end else if (r_it > i_init_lim) begin
                                    e.kind = K_FAIL; e.error_code = E_TIMEOUT; e.mosi_byte = '0;
                                end else begin
                                    n_idx = 6'd55; n_arg = '0; n_ret = R_CMD55;
                                    n_ms = '0; n_phase = P_CMD_WAIT;
                                end
                            end
                            R_OCR, R_FIN: begin
                                if (r_ret == R_OCR) n_bm = n_rs[30];
                                n_sel = 1'b0; n_phase = P_FINISH;
                            end
                            R_CMD18, R_CMD25, R_WDONE: begin
                                e.kind = K_DONE; e.mosi_byte = '0;
                                n_phase = (r_ret == R_CMD18) ? P_RD_READY : P_WR_READY;
                            end
                            R_CMD12: begin
                                n_ret = R_FIN; n_ms = '0; n_phase = P_BUSY;
                            end
                            R_STOPBUSY: begin
                                n_idx = 6'd13; n_arg = '0; n_ret = R_CMD13; n_ms = '0;
                                n_phase = P_CMD_WAIT;
                            end
                            R_CMD13: n_phase = P_STATUS;
                            default: begin
                                e.kind = K_FAIL; e.error_code = E_TIMEOUT; e.mosi_byte = '0;
                            end
                        endcase
                    end
                end
                4'(C_INIT): if (r_phase == P_IDLE) begin
                    n_slow = 1'b1; n_sel = 1'b0; n_cnt = '0; n_phase = P_DUMMY;
                    nres = 2'd1; e.mosi_byte = 8'hff;
                end
                4'(C_RSTART), 4'(C_WSTART): if (r_phase == P_IDLE) begin
                    n_sel = 1'b1; n_slow = 1'b0;
                    n_idx = (i_req.cmd == 4'(C_RSTART)) ? 6'd18 : 6'd25;
                    n_ret = (i_req.cmd == 4'(C_RSTART)) ? R_CMD18 : R_CMD25;
                    n_arg = r_bm ? i_req.block_addr : {i_req.block_addr[22:0], 9'd0};
                    n_ms = '0; n_phase = P_CMD_WAIT; nres = 2'd1; e.mosi_byte = 8'hff;
                end
                4'(C_RBLOCK): if (r_phase == P_RD_READY) begin
                    n_ms = '0; n_phase = P_TOKEN; nres = 2'd1; e.mosi_byte = 8'hff;
                end
                4'(C_RSTOP): if (r_phase == P_RD_READY) begin
                    n_idx = 6'd12; n_arg = '0; n_ret = R_CMD12; n_cnt = '0;
                    n_phase = P_CMD_SEND; nres = 2'd1;
                    e.mosi_byte = cmd_byte(3'd0, 6'd12, 32'd0);
                end
                4'(C_WBYTE): begin
                    if (r_phase == P_WR_READY) begin
                        n_rs = {24'd0, i_req.write_byte}; n_phase = P_WSTUFF;
                        nres = 2'd1; e.mosi_byte = 8'hff;
                    end else if (r_phase == P_WNEED) begin
                        n_phase = P_WDATA; nres = 2'd1; e.mosi_byte = i_req.write_byte;
                    end
                end
                4'(C_WSTOP): if (r_phase == P_WR_READY) begin
                    n_phase = P_STOPTOK; nres = 2'd1; e.mosi_byte = 8'hfd;
                end
                4'(C_TICK): begin
                    if (r_ms != 16'hffff) n_ms = r_ms + 16'd1;
                    if (r_it != 16'hffff) n_it = r_it + 16'd1;
                end
                default: ;
            endcase
            if (nres != 2'd0 && e.kind == K_FAIL) begin
                n_sel = 1'b0; n_slow = 1'b0; n_phase = P_IDLE;
            end
            e.high_capacity = n_bm;
            if (e.kind == K_XFER) begin
                e.select_active = n_sel;
                e.slow_clock = n_slow;
            end else e.mosi_byte = '0;
            if (nres == 2'd2) res1 = e;
            else res0 = e;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= P_IDLE; r_ret <= P_IDLE; r_cnt <= '0; r_ms <= '0; r_it <= '0;
            r_bm <= 1'b0; r_sel <= 1'b0; r_slow <= 1'b0; r_rs <= '0; r_arg <= '0;
            r_idx <= '0;
        end else begin
            r_phase <= n_phase; r_ret <= n_ret; r_cnt <= n_cnt; r_ms <= n_ms; r_it <= n_it;
            r_bm <= n_bm; r_sel <= n_sel; r_slow <= n_slow; r_rs <= n_rs; r_arg <= n_arg;
            r_idx <= n_idx;
        end
    end
endmodule

@@ src/sdspi_out.sv @@
// Result queue: takes up to two result items per cycle, hands out one per cycle while i_ready is high.
// Depends on sdspi_pkg.
module sdspi_out
    import sdspi_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [1:0] i_n,
    input  t_res       i_res0,
    input  t_res       i_res1,
    output logic       o_room,
    output logic       o_valid,
    input  logic       i_ready,
    output t_res       o_res
);
    t_res       r_mem [4];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;
    logic       w_pop;

    assign o_valid = (r_cnt != 3'd0);
    assign o_res   = r_mem[r_rp];
    assign w_pop   = o_valid && i_ready;
    assign o_room  = (r_cnt <= 3'd2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + i_n;
            if (w_pop) r_rp <= r_rp + 2'd1;
            r_cnt <= r_cnt + {1'b0, i_n} - {2'b00, w_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_n != 2'd0) r_mem[r_wp] <= i_res0;
        if (i_n == 2'd2) r_mem[r_wp + 2'd1] <= i_res1;
    end
endmodule

@@ bench/tb_top.sv @@
// Self-checking bench for sd_spi_host_sequencer_top: a card-aware generator drives
// requests and card bytes, a built-in predictor checks every result item in order.
// Depends on sdspi_pkg and the sequencer RTL.
`timescale 1ns / 1ps

module tb_top;
    import sdspi_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [3:0]  i_cmd = '0;
    logic [7:0]  i_miso_byte = '0;
    logic [31:0] i_block_addr = '0;
    logic [7:0]  i_write_byte = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [2:0]  o_kind;
    logic [7:0]  o_mosi_byte;
    logic        o_select_active;
    logic        o_slow_clock;
    logic [7:0]  o_data_out;
    logic [2:0]  o_error_code;
    logic        o_last;
    logic        o_high_capacity;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;

    sd_spi_host_sequencer_top dut (.*);

    // card model state
    t_phase      ph, ret_ph;
    logic [9:0]  cnt;
    logic [15:0] ms_t, init_t;
    logic        bmode, sel, slow;
    logic [31:0] shreg, carg;
    logic [5:0]  cidx;
    logic [15:0] lim_resp, lim_init, lim_tok, lim_busy;
    t_res        exp_q[$];

    int s_idle, r_idle, hold_left, errors;
    bit hold_req;

    function automatic t_res mk_res(logic [2:0] k, logic [7:0] m, logic s, logic sl,
                                    logic [7:0] d, logic [2:0] e, logic l, logic hc);
        t_res r;
        r.kind = k; r.mosi_byte = m; r.select_active = s; r.slow_clock = sl;
        r.data_out = d; r.error_code = e; r.last = l; r.high_capacity = hc;
        return r;
    endfunction

    function automatic void put(logic [2:0] k, logic [7:0] m, logic [7:0] d, logic [2:0] e,
                                logic l);
        exp_q.push_back(mk_res(k, m, k == K_XFER && sel, k == K_XFER && slow, d, e, l, bmode));
    endfunction

    function automatic void xfer(logic [7:0] b);
        put(K_XFER, b, 8'h00, 3'd0, 1'b0);
    endfunction

    function automatic void fail_seq(logic [2:0] code);
        sel = 0; slow = 0; ph = P_IDLE;
        put(K_FAIL, 8'h00, 8'h00, code, 1'b0);
    endfunction

    function automatic void done_seq(t_phase nxt);
        ph = nxt;
        put(K_DONE, 8'h00, 8'h00, 3'd0, 1'b0);
    endfunction

    function automatic logic [7:0] frame_byte(int i);
        case (i)
            0: return 8'h40 | {2'b00, cidx};
            1: return carg[31:24];
            2: return carg[23:16];
            3: return carg[15:8];
            4: return carg[7:0];
            default: return (cidx == 0) ? 8'h95 : (cidx == 8) ? 8'h87 : 8'hff;
        endcase
    endfunction

    function automatic void begin_cmd(logic [5:0] idx, logic [31:0] arg, t_phase cont);
        cidx = idx; carg = arg; ret_ph = cont; ms_t = 0; ph = P_CMD_WAIT;
        xfer(8'hff);
    endfunction

    function automatic void begin_r32(t_phase cont);
        ret_ph = cont; shreg = 0; cnt = 0; ph = P_R32;
        xfer(8'hff);
    endfunction

    function automatic void begin_busy(t_phase cont);
        ret_ph = cont; ms_t = 0; ph = P_BUSY;
        xfer(8'hff);
    endfunction

    function automatic void begin_finish();
        sel = 0; ph = P_FINISH;
        xfer(8'hff);
    endfunction

    function automatic void resume(t_phase k);
        case (k)
            R_CMD0: begin_cmd(6'd8, 32'h1aa, R_CMD8);
            R_CMD8: begin_r32(R_R7);
            R_R7: begin
                if (shreg != 32'h1aa) fail_seq(E_ECHO);
                else begin
                    init_t = 0;
                    begin_cmd(6'd55, 0, R_CMD55);
                end
            end
            R_CMD55: begin_cmd(6'd41, 32'h4000_0000, R_CMD41);
            R_CMD41: begin
                if (shreg[7:0] == 0) begin_cmd(6'd58, 0, R_CMD58);
                else if (init_t > lim_init) fail_seq(E_TIMEOUT);
                else begin_cmd(6'd55, 0, R_CMD55);
            end
            R_CMD58: begin_r32(R_OCR);
            R_OCR: begin
                bmode = shreg[30];
                begin_finish();
            end
            R_CMD18: done_seq(P_RD_READY);
            R_CMD25: done_seq(P_WR_READY);
            R_CMD12: begin_busy(R_FIN);
            R_FIN: begin_finish();
            R_WDONE: done_seq(P_WR_READY);
            R_STOPBUSY: begin_cmd(6'd13, 0, R_CMD13);
            R_CMD13: begin
                ph = P_STATUS;
                xfer(8'hff);
            end
            default: fail_seq(E_TIMEOUT);
        endcase
    endfunction

    function automatic void on_card(logic [7:0] b);
        case (ph)
            P_DUMMY: begin
                cnt++;
                if (cnt < DUMMY_BYTES_DEF) xfer(8'hff);
                else begin
                    sel = 1;
                    begin_cmd(6'd0, 0, R_CMD0);
                end
            end
            P_CMD_WAIT: begin
                if (b == 8'hff) begin
                    cnt = 0; ph = P_CMD_SEND;
                    xfer(frame_byte(0));
                end else if (ms_t >= lim_busy) fail_seq(E_BUSY);
                else xfer(8'hff);
            end
            P_CMD_SEND: begin
                cnt++;
                if (cnt < 6) xfer(frame_byte(cnt));
                else begin
                    ms_t = 0;
                    ph = (cidx == 12) ? P_STUFF : P_CMD_R1;
                    xfer(8'hff);
                end
            end
            P_STUFF: begin
                ph = P_CMD_R1;
                xfer(8'hff);
            end
            P_CMD_R1: begin
                if (b[7]) begin
                    if (ms_t >= lim_resp) fail_seq(E_TIMEOUT);
                    else xfer(8'hff);
                end else if (cidx != 12 && b[7:1] != 0) fail_seq(E_R1);
                else begin
                    shreg = {24'h0, b};
                    resume(ret_ph);
                end
            end
            P_R32: begin
                shreg = {shreg[23:0], b};
                cnt++;
                if (cnt < 4) xfer(8'hff);
                else resume(ret_ph);
            end
            P_BUSY: begin
                if (b == 8'hff) resume(ret_ph);
                else if (ms_t >= lim_busy) fail_seq(E_BUSY);
                else xfer(8'hff);
            end
            P_FINISH: begin
                slow = 0;
                done_seq(P_IDLE);
            end
            P_TOKEN: begin
                if (b == 8'hff) begin
                    if (ms_t >= lim_tok) fail_seq(E_TIMEOUT);
                    else xfer(8'hff);
                end else if (b != 8'hfe) fail_seq(E_TOKEN);
                else begin
                    cnt = 0; ph = P_RDATA;
                    xfer(8'hff);
                end
            end
            P_RDATA: begin
                put(K_RDATA_OUT, 8'h00, b, 3'd0, (cnt + 1 >= BLOCK_BYTES_DEF));
                cnt++;
                if (cnt >= BLOCK_BYTES_DEF) begin
                    cnt = 0; ph = P_RCRC;
                end
                xfer(8'hff);
            end
            P_RCRC: begin
                cnt++;
                if (cnt < 2) xfer(8'hff);
                else done_seq(P_RD_READY);
            end
            P_WSTUFF: begin
                ph = P_WTOKEN;
                xfer(8'hfc);
            end
            P_WTOKEN: begin
                cnt = 0; ph = P_WDATA;
                xfer(shreg[7:0]);
            end
            P_WDATA: begin
                cnt++;
                if (cnt < BLOCK_BYTES_DEF) begin
                    ph = P_WNEED;
                    put(K_NEED, 8'h00, 8'h00, 3'd0, 1'b0);
                end else begin
                    cnt = 0; ph = P_WCRC;
                    xfer(8'hff);
                end
            end
            P_WCRC: begin
                cnt++;
                if (cnt >= 2) ph = P_WRESP;
                xfer(8'hff);
            end
            P_WRESP: begin
                if (b[4:0] != 5'h05) fail_seq(E_WREJ);
                else begin_busy(R_WDONE);
            end
            P_STOPTOK: begin
                ph = P_STOPDUM;
                xfer(8'hff);
            end
            P_STOPDUM: begin_busy(R_STOPBUSY);
            P_STATUS: begin
                if (b != 0) fail_seq(E_STATUS);
                else begin_finish();
            end
            default: ;
        endcase
    endfunction

    function automatic void seq_step(t_req q);
        case (q.cmd)
            C_BYTE: on_card(q.miso_byte);
            C_INIT: if (ph == P_IDLE) begin
                slow = 1; sel = 0; cnt = 0; ph = P_DUMMY;
                xfer(8'hff);
            end
            C_RSTART, C_WSTART: if (ph == P_IDLE) begin
                sel = 1; slow = 0;
                begin_cmd((q.cmd == C_RSTART) ? 6'd18 : 6'd25,
                          bmode ? q.block_addr : {q.block_addr[22:0], 9'h0},
                          (q.cmd == C_RSTART) ? R_CMD18 : R_CMD25);
            end
            C_RBLOCK: if (ph == P_RD_READY) begin
                ms_t = 0; ph = P_TOKEN;
                xfer(8'hff);
            end
            C_RSTOP: if (ph == P_RD_READY) begin
                cidx = 12; carg = 0; ret_ph = R_CMD12; cnt = 0; ph = P_CMD_SEND;
                xfer(frame_byte(0));
            end
            C_WBYTE: begin
                if (ph == P_WR_READY) begin
                    shreg = {24'h0, q.write_byte}; ph = P_WSTUFF;
                    xfer(8'hff);
                end else if (ph == P_WNEED) begin
                    ph = P_WDATA;
                    xfer(q.write_byte);
                end
            end
            C_WSTOP: if (ph == P_WR_READY) begin
                ph = P_STOPTOK;
                xfer(8'hfd);
            end
            C_TICK: begin
                if (ms_t != 16'hffff) ms_t++;
                if (init_t != 16'hffff) init_t++;
            end
            default: ;
        endcase
    endfunction

    // plausible card reply for the current phase, with some faults mixed in
    function automatic logic [7:0] card_reply();
        int r;
        r = $urandom_range(0, 99);
        case (ph)
            P_CMD_WAIT: return (r < 85) ? 8'hff : 8'($urandom_range(0, 254));
            P_CMD_R1: begin
                if (r < 25) return 8'h80 | 8'($urandom);
                if (r < 28) return 8'($urandom);
                if (cidx == 41) return (r < 60) ? 8'h00 : 8'h01;
                if (cidx == 0 || cidx == 8 || cidx == 55) return 8'h01;
                return 8'h00;
            end
            P_R32: begin
                if (ret_ph == R_R7 && r < 95) return 8'(32'h1aa >> (8 * (3 - cnt)));
                return 8'($urandom);
            end
            P_BUSY: return (r < 60) ? 8'hff : 8'h00;
            P_TOKEN: return (r < 30) ? 8'hff : (r < 95) ? 8'hfe : 8'($urandom);
            P_WRESP: return (r < 90) ? {3'($urandom), 5'h05} : 8'($urandom);
            P_STATUS: return (r < 90) ? 8'h00 : 8'($urandom);
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic t_req next_req();
        t_req q;
        int r;
        r = $urandom_range(0, 99);
        q.miso_byte = card_reply();
        q.block_addr = $urandom;
        q.write_byte = $urandom;
        q.cmd = C_BYTE;
        if (r < 4) q.cmd = C_TICK;
        else if (r < 7) q.cmd = 4'($urandom_range(0, 15));
        else begin
            case (ph)
                P_IDLE: case ($urandom_range(0, 2))
                    0: q.cmd = C_INIT;
                    1: q.cmd = C_RSTART;
                    default: q.cmd = C_WSTART;
                endcase
                P_RD_READY: q.cmd = (r < 75) ? C_RBLOCK : C_RSTOP;
                P_WR_READY: q.cmd = (r < 80) ? C_WBYTE : C_WSTOP;
                P_WNEED: q.cmd = C_WBYTE;
                default: q.cmd = C_BYTE;
            endcase
        end
        return q;
    endfunction

    task automatic send(t_req q);
        seq_step(q);
        i_valid <= 1'b1;
        i_cmd <= q.cmd;
        i_miso_byte <= q.miso_byte;
        i_block_addr <= q.block_addr;
        i_write_byte <= q.write_byte;
        @(negedge i_clk);
        while (!o_ready) @(negedge i_clk);
        @(posedge i_clk);
        if ($urandom_range(0, 99) < s_idle) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    task automatic cfg_write(logic [1:0] idx, logic [15:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        while (!o_cfg_ready) @(negedge i_clk);
        @(posedge i_clk);
        case (idx)
            REG_RESP: lim_resp = val;
            REG_INIT: lim_init = val;
            REG_TOKEN: lim_tok = val;
            default: lim_busy = val;
        endcase
    endtask

    task automatic cfg_all(logic [15:0] a, logic [15:0] b, logic [15:0] c, logic [15:0] d);
        cfg_write(REG_RESP, a);
        cfg_write(REG_INIT, b);
        cfg_write(REG_TOKEN, c);
        cfg_write(REG_BUSY, d);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (exp_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic run_random(int n);
        repeat (n) send(next_req());
    endtask

    t_req dir_req[$];
    bit   dir_chk[$];
    t_res dir_exp[$];

    task automatic add_row(logic [3:0] c, logic [7:0] mb, logic [31:0] a, logic [7:0] wb,
                           bit chk, t_res e);
        t_req q;
        q.cmd = c; q.miso_byte = mb; q.block_addr = a; q.write_byte = wb;
        dir_req.push_back(q);
        dir_chk.push_back(chk);
        dir_exp.push_back(e);
    endtask

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("sd_spi_host_sequencer_top test failed");
        $finish;
    end

    always @(posedge i_clk) begin
        if (hold_req) begin
            hold_left = 300;
            hold_req = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(0, 99) >= r_idle);
        end
    end

    always @(negedge i_clk) begin
        t_res got, want;
        if (i_rst_n && o_valid && i_ready) begin
            got = mk_res(o_kind, o_mosi_byte, o_select_active, o_slow_clock, o_data_out,
                         o_error_code, o_last, o_high_capacity);
            if (exp_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result item %p", got);
            end else begin
                want = exp_q.pop_front();
                if (got !== want) begin
                    errors++;
                    if (errors <= 10) $display("mismatch: expected %p got %p", want, got);
                end
            end
        end
    end

    initial begin
        t_res none;
        int n0;
        none = '0;
        lim_resp = 1000; lim_init = 1250; lim_tok = 5000; lim_busy = 1000;
        ph = P_IDLE; ret_ph = P_IDLE; cnt = 0; ms_t = 0; init_t = 0;
        bmode = 0; sel = 0; slow = 0; shreg = 0; carg = 0; cidx = 0;
        errors = 0; hold_left = 0; hold_req = 0;
        s_idle = 15; r_idle = 85;

        // requests that give no result, then a read start that dies on an R1 error, then init
        add_row(C_TICK, 8'h00, 32'h0, 8'h00, 0, none);
        add_row(4'hf, 8'hff, 32'hffff_ffff, 8'hff, 0, none);
        add_row(C_BYTE, 8'h00, 32'h0, 8'h00, 0, none);
        add_row(C_RBLOCK, 8'h00, 32'h0, 8'h00, 0, none);
        add_row(C_RSTOP, 8'h00, 32'h0, 8'h00, 0, none);
        add_row(C_WSTOP, 8'h00, 32'h0, 8'h00, 0, none);
        add_row(C_WBYTE, 8'h00, 32'h0, 8'hff, 0, none);
        add_row(C_RSTART, 8'h00, 32'hffff_ffff, 8'h00, 1,
                mk_res(K_XFER, 8'hff, 1, 0, 0, 0, 0, 0));
        add_row(C_BYTE, 8'h00, 32'h0, 8'h00, 1, mk_res(K_XFER, 8'hff, 1, 0, 0, 0, 0, 0));
        add_row(C_BYTE, 8'hff, 32'h0, 8'h00, 1, mk_res(K_XFER, 8'h52, 1, 0, 0, 0, 0, 0));
        repeat (6) add_row(C_BYTE, 8'h5a, 32'h0, 8'h00, 0, none);
        add_row(C_BYTE, 8'h04, 32'h0, 8'h00, 1, mk_res(K_FAIL, 0, 0, 0, 0, E_R1, 0, 0));
        add_row(C_INIT, 8'h00, 32'h0, 8'h00, 1, mk_res(K_XFER, 8'hff, 0, 1, 0, 0, 0, 0));
        add_row(C_TICK, 8'h00, 32'h0, 8'h00, 0, none);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_req[i]) begin
            n0 = exp_q.size();
            seq_step(dir_req[i]);
            if (dir_chk[i]) begin
                while (exp_q.size() > n0) void'(exp_q.pop_back());
                exp_q.push_back(dir_exp[i]);
            end
            // send() steps the model again, so undo by driving the raw item here
            i_valid <= 1'b1;
            i_cmd <= dir_req[i].cmd;
            i_miso_byte <= dir_req[i].miso_byte;
            i_block_addr <= dir_req[i].block_addr;
            i_write_byte <= dir_req[i].write_byte;
            @(negedge i_clk);
            while (!o_ready) @(negedge i_clk);
            @(posedge i_clk);
        end
        drain();

        cfg_all(16'($urandom_range(3, 60)), 16'($urandom_range(3, 60)),
                16'($urandom_range(3, 60)), 16'($urandom_range(3, 60)));
        run_random(125);
        drain();

        s_idle = 85; r_idle = 15;
        cfg_all(16'd1, 16'd1, 16'd1, 16'd1);
        run_random(125);
        drain();

        s_idle = 0; r_idle = 0;
        cfg_all(16'hffff, 16'hffff, 16'hffff, 16'hffff);
        hold_req = 1;
        run_random(130);
        drain();

        if (errors == 0) begin
            $display("sd_spi_host_sequencer_top test passed");
        end else begin
            $display("sd_spi_host_sequencer_top test failed");
        end
        $finish;
    end

endmodule
